/* rtl/core/ics_pkg.sv */
// Shared types and byte constants for the invisible character stripper.
package ics_pkg;

   // Four byte lookahead window, entry 0 is the scan position.
   typedef logic [3:0][7:0] ics_win_type;

   // Outcome of matching the scan position against the banned patterns.
   typedef struct packed {
      logic       hit;
      logic [2:0] len;
   } ics_match_type;

   localparam logic [7:0] CH_CTRL_END = 8'h08;
   localparam logic [7:0] CH_TAB      = 8'h09;
   localparam logic [7:0] CH_SPACE    = 8'h20;
   localparam logic [7:0] CH_DEL      = 8'h7F;
   localparam logic [7:0] CH_LEAD_C2  = 8'hC2;
   localparam logic [7:0] CH_LEAD_E1  = 8'hE1;
   localparam logic [7:0] CH_LEAD_E2  = 8'hE2;
   localparam logic [7:0] CH_LEAD_EF  = 8'hEF;
   localparam logic [7:0] CH_LEAD_F3  = 8'hF3;
   localparam logic [7:0] CH_CONT_80  = 8'h80;
   localparam logic [7:0] CH_CONT_81  = 8'h81;
   localparam logic [7:0] CH_CONT_8E  = 8'h8E;
   localparam logic [7:0] CH_CONT_A0  = 8'hA0;
   localparam logic [7:0] CH_CONT_AD  = 8'hAD;
   localparam logic [7:0] CH_CONT_AF  = 8'hAF;
   localparam logic [7:0] CH_CONT_BB  = 8'hBB;
   localparam logic [7:0] CH_CONT_BF  = 8'hBF;

endpackage

/* rtl/core/invisible_char_stripper_core.sv */
// Top level of the invisible character stripper: window, decision logic and result queue.
//
// The block takes a string one byte per transaction and passes on the bytes that are
// neither control bytes (08h and tab apart) nor part of an invisible UTF-8 sequence, up
// to csr_wr_data bytes per string. Ordinary bytes are accepted at one per clock cycle while
// the result queue has room; each decision is made by one pass of the pattern matcher over
// a four byte lookahead window held in registers. The transaction that ends a string
// (tlast, or a zero byte acting as terminator) is followed by a flush sequencer that
// decides the bytes still held, one decision at a time, and input is held off until the
// flush is over. Results leave through a two entry queue, so a waiting result does not
// stop the next byte from being accepted. The final result of each string carries tlast
// together with the removed and truncated flags. There is no clearing pass.
module invisible_char_stripper_core
   import ics_pkg::*;
#(
   parameter int COUNT_BITS = 16
)
(
   input  logic        clock,
   input  logic        reset,
   // Configuration: output limit per string.
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Input stream. tdata: [7:0] in_byte. tlast: is_last.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   // Result stream. tdata: [7:0] out_byte, [8] removed_any, [9] truncated, [15:10] zero.
   // tuser: byte_valid. tlast: end_of_run.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,
   output logic        rsp_tuser,
   output logic        rsp_tlast
);

   // Compare width wide enough for both the counter and the 16 bit limit.
   localparam int CW = (COUNT_BITS > 16) ? COUNT_BITS : 16;

   typedef enum logic [1:0] {
      ST_RUN   = 2'b01,
      ST_FLUSH = 2'b10
   } state_type;

   typedef struct packed {
      logic       truncated;
      logic       removed_any;
      logic       end_of_run;
      logic       byte_valid;
      logic [7:0] out_byte;
   } rsp_type;

   state_type             state_ff, state_in;
   ics_win_type           win_ff, win_in;
   logic [2:0]            win_cnt_ff, win_cnt_in;
   logic [COUNT_BITS-1:0] emitted_ff, emitted_in;
   logic                  found_ff, found_in;
   logic                  stopped_ff, stopped_in;
   logic                  ended_ff, ended_in;
   logic                  last_ff, last_in;
   logic                  pend_vld_ff, pend_vld_in;
   logic [7:0]            pend_byte_ff, pend_byte_in;
   logic [15:0]           out_limit_ff;
   rsp_type               q_ff [2];
   rsp_type               q_in [2];
   logic [1:0]            q_cnt_ff, q_cnt_in;

   logic          room, acc, pop, push;
   rsp_type       push_data;
   logic          app_ok;
   ics_win_type   app_win;
   logic [2:0]    app_cnt;
   ics_win_type   dec_win;
   logic [2:0]    dec_cnt;
   ics_match_type dec_match;
   logic [CW-1:0] emit_ext, lim_ext, max_ext, lim_eff;
   logic          lim_hit, dec_stop, dec_emit, dec_commit;
   logic [2:0]    dec_k_raw, dec_k;
   ics_win_type   dec_next_win;
   logic          wr_idx;

   // Handshakes. The queue has room as long as it is not full.
   assign room       = (q_cnt_ff != 2'd2);
   assign req_tready = (state_ff == ST_RUN) && room;
   assign acc        = req_tvalid && req_tready;
   assign rsp_tvalid = (q_cnt_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;

   assign rsp_tdata = {6'd0, q_ff[0].truncated, q_ff[0].removed_any, q_ff[0].out_byte};
   assign rsp_tuser = q_ff[0].byte_valid;
   assign rsp_tlast = q_ff[0].end_of_run;

   // The incoming byte joins the window unless it is a terminator or the string has ended.
   // While running, at most three bytes are held, so the two low count bits index the slot.
   always_comb begin
      app_ok  = !ended_ff && (req_tdata != 8'd0);
      app_win = win_ff;
      if (app_ok) begin
         app_win[win_cnt_ff[1:0]] = req_tdata;
      end
      app_cnt = win_cnt_ff + {2'd0, app_ok};
   end

   // The decision always looks at the stored window in flush, at the extended one otherwise.
   assign dec_win = (state_ff == ST_FLUSH) ? win_ff : app_win;
   assign dec_cnt = (state_ff == ST_FLUSH) ? win_cnt_ff : app_cnt;

   ics_match u_match (
      .win       (dec_win),
      .match_out (dec_match)
   );

   // The limit is the smaller of the configured value and the largest count.
   assign emit_ext = CW'(emitted_ff);
   assign lim_ext  = CW'(out_limit_ff);
   assign max_ext  = CW'({COUNT_BITS{1'b1}});
   assign lim_eff  = (lim_ext < max_ext) ? lim_ext : max_ext;
   assign lim_hit  = (emit_ext >= lim_eff);
   assign dec_stop = stopped_ff || lim_hit;
   assign dec_emit = !dec_match.hit && !dec_stop;

   // A removed sequence consumes its length, clipped to what is held; a kept byte one.
   assign dec_k_raw    = dec_match.hit ? dec_match.len : 3'd1;
   assign dec_k        = (dec_k_raw > dec_cnt) ? dec_cnt : dec_k_raw;
   assign dec_next_win = dec_win >> {dec_k, 3'b000};

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      win_cnt_in   = win_cnt_ff;
      emitted_in   = emitted_ff;
      found_in     = found_ff;
      stopped_in   = stopped_ff;
      ended_in     = ended_ff;
      last_in      = last_ff;
      pend_vld_in  = pend_vld_ff;
      pend_byte_in = pend_byte_ff;
      push         = 1'b0;
      push_data    = '0;
      dec_commit   = 1'b0;

      case (state_ff)
         ST_RUN: begin
            if (acc) begin
               if (ended_ff) begin
                  // Bytes after a terminator are dropped until the string is closed.
                  if (req_tlast) begin
                     state_in = ST_FLUSH;
                     last_in  = 1'b1;
                  end
               end else if (req_tdata == 8'd0 || req_tlast) begin
                  win_in     = app_win;
                  win_cnt_in = app_cnt;
                  state_in   = ST_FLUSH;
                  last_in    = req_tlast;
               end else if (app_cnt == 3'd4) begin
                  // Three bytes of lookahead are known: decide the scan position.
                  dec_commit = 1'b1;
                  if (dec_emit) begin
                     push      = 1'b1;
                     push_data = '{truncated: 1'b0, removed_any: 1'b0, end_of_run: 1'b0,
                                   byte_valid: 1'b1, out_byte: dec_win[0]};
                  end
               end else begin
                  win_in     = app_win;
                  win_cnt_in = app_cnt;
               end
            end
         end
         ST_FLUSH: begin
            if (room) begin
               if (win_cnt_ff != 3'd0) begin
                  // A kept byte is held back one step so that the last one can carry
                  // the end of run marker.
                  dec_commit = 1'b1;
                  if (dec_emit) begin
                     if (pend_vld_ff) begin
                        push      = 1'b1;
                        push_data = '{truncated: 1'b0, removed_any: 1'b0, end_of_run: 1'b0,
                                      byte_valid: 1'b1, out_byte: pend_byte_ff};
                     end
                     pend_vld_in  = 1'b1;
                     pend_byte_in = dec_win[0];
                  end
               end else if (last_ff) begin
                  push      = 1'b1;
                  push_data = '{truncated: stopped_ff, removed_any: found_ff,
                                end_of_run: 1'b1, byte_valid: pend_vld_ff,
                                out_byte: pend_vld_ff ? pend_byte_ff : 8'd0};
                  state_in    = ST_RUN;
                  win_in      = '0;
                  win_cnt_in  = 3'd0;
                  emitted_in  = '0;
                  found_in    = 1'b0;
                  stopped_in  = 1'b0;
                  ended_in    = 1'b0;
                  last_in     = 1'b0;
                  pend_vld_in = 1'b0;
               end else begin
                  // Terminator without end of string: flush and wait for tlast.
                  if (pend_vld_ff) begin
                     push      = 1'b1;
                     push_data = '{truncated: 1'b0, removed_any: 1'b0, end_of_run: 1'b0,
                                   byte_valid: 1'b1, out_byte: pend_byte_ff};
                  end
                  pend_vld_in = 1'b0;
                  ended_in    = 1'b1;
                  state_in    = ST_RUN;
               end
            end
         end
         default: begin
            state_in = ST_RUN;
         end
      endcase

      if (dec_commit) begin
         win_in     = dec_next_win;
         win_cnt_in = dec_cnt - dec_k;
         stopped_in = dec_stop;
         if (dec_match.hit) begin
            found_in = 1'b1;
         end
         if (dec_emit) begin
            emitted_in = emitted_ff + COUNT_BITS'(1);
         end
      end
   end

   // Two entry result queue, head in entry 0.
   assign wr_idx = 1'(q_cnt_ff - {1'b0, pop});

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      if (pop) begin
         q_in[0] = q_ff[1];
      end
      if (push) begin
         q_in[wr_idx] = push_data;
      end
      q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_RUN;
         win_ff       <= '0;
         win_cnt_ff   <= 3'd0;
         emitted_ff   <= '0;
         found_ff     <= 1'b0;
         stopped_ff   <= 1'b0;
         ended_ff     <= 1'b0;
         last_ff      <= 1'b0;
         pend_vld_ff  <= 1'b0;
         q_cnt_ff     <= 2'd0;
         out_limit_ff <= 16'd255;
      end else begin
         state_ff    <= state_in;
         win_ff      <= win_in;
         win_cnt_ff  <= win_cnt_in;
         emitted_ff  <= emitted_in;
         found_ff    <= found_in;
         stopped_ff  <= stopped_in;
         ended_ff    <= ended_in;
         last_ff     <= last_in;
         pend_vld_ff <= pend_vld_in;
         q_cnt_ff    <= q_cnt_in;
         if (csr_wr_en) begin
            out_limit_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_byte_ff <= pend_byte_in;
      q_ff[0]      <= q_in[0];
      q_ff[1]      <= q_in[1];
   end

   // The queue never holds more than two results.
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_cnt_ff <= 2'd2)
      else $error("result queue overflow");

   // While bytes stream in, the window holds at most three bytes.
   a_run_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (win_cnt_ff <= 3'd3))
      else $error("window over-full outside flush");

   // A kept byte is never the zero terminator.
   a_kept_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[7:0] != 8'd0))
      else $error("zero byte emitted as kept");

   // Summary flags appear only on the final result of a string.
   a_flags_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[9:8] == 2'd0))
      else $error("summary flags on a non-final result");

   // Closing a string returns the per-string state to its reset value.
   a_string_clear: assert property (@(posedge clock) disable iff (reset)
      (push && push_data.end_of_run) |=> (emitted_ff == '0 && !found_ff && !ended_ff))
      else $error("string state not cleared after final result");

endmodule

/* rtl/core/ics_match.sv */
// Pattern matcher giving the length of a banned sequence at the window head.
module ics_match
   import ics_pkg::*;
(
   input  ics_win_type   win,
   output ics_match_type match_out
);

   logic [7:0] b0, b1, b2, b3;

   assign b0 = win[0];
   assign b1 = win[1];
   assign b2 = win[2];
   assign b3 = win[3];

   always_comb begin
      match_out = '0;
      if (b0 < CH_CTRL_END || (b0 > CH_TAB && b0 < CH_SPACE) || b0 == CH_DEL) begin
         match_out = '{hit: 1'b1, len: 3'd1};
      end else if (b0 == CH_LEAD_C2 && (b1 == CH_CONT_A0 || b1 == CH_CONT_AD)) begin
         match_out = '{hit: 1'b1, len: 3'd2};
      end else if (b0 == CH_LEAD_E2 && b1 == CH_CONT_80
                   && b2 >= CH_CONT_80 && b2 <= CH_CONT_AF) begin
         match_out = '{hit: 1'b1, len: 3'd3};
      end else if (b0 == CH_LEAD_E2 && b1 == CH_CONT_81
                   && b2 >= CH_CONT_A0 && b2 <= CH_CONT_AF) begin
         match_out = '{hit: 1'b1, len: 3'd3};
      end else if (b0 == CH_LEAD_E1 && b1 == CH_CONT_A0 && b2 == CH_CONT_8E) begin
         match_out = '{hit: 1'b1, len: 3'd3};
      end else if (b0 == CH_LEAD_EF && b1 == CH_CONT_BB && b2 == CH_CONT_BF) begin
         match_out = '{hit: 1'b1, len: 3'd3};
      end else if (b0 == CH_LEAD_F3 && b1 == CH_CONT_A0 && b2 == CH_CONT_80
                   && b3 >= CH_CONT_80 && b3 <= CH_CONT_BF) begin
         match_out = '{hit: 1'b1, len: 3'd4};
      end else if (b0 == CH_LEAD_F3 && b1 == CH_CONT_A0 && b2 == CH_CONT_81
                   && b3 >= CH_CONT_80 && b3 <= CH_CONT_AF) begin
         match_out = '{hit: 1'b1, len: 3'd4};
      end
   end

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the invisible character stripper core.
module testbench;
   import ics_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COUNT_BITS = 16;
   localparam int CLK_HALF = 10;
   localparam int RESET_CYCLES = 8;
   // Cycles without any transaction after which the run is declared hung.
   localparam int STALL_LIMIT = 2000;
   // Length of each deliberate hold-off on the result side.
   localparam int HOLD_LEN = 120;
   // Settling time once every expected result has arrived, covering the flush after a
   // string end and the output queue.
   localparam int SETTLE_CYCLES = 12;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

   // Which side of the block idles, and how often.
   typedef enum logic [1:0] {
      PACE_RX_STALLS,
      PACE_TX_GAPS,
      PACE_FULL_RATE
   } pace_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_run;
      logic       removed_any;
      logic       truncated;
   } strip_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = 16'd0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] in_byte
   logic        req_tlast = 1'b0;   // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;          // [7:0] out_byte, [8] removed_any, [9] truncated, rest zero
   logic        rsp_tuser;          // byte_valid
   logic        rsp_tlast;          // end_of_run

   // Bytes waiting to be offered, and results the block still owes us.
   byte_item_type    pending_bytes[$];
   strip_result_type expected_results[$];

   pace_type pace = PACE_RX_STALLS;
   int       mismatch_count = 0;
   int       bytes_accepted = 0;
   int       quiet_cycles = 0;
   logic     req_taken = 1'b0;

   // Model of the stripper: lookahead window, counters and per-string flags.
   logic [15:0]           limit_reg = 16'd255;
   logic [7:0]            win_bytes[3];
   int                    win_fill = 0;
   logic [COUNT_BITS-1:0] sent_count = '0;
   logic                  saw_banned = 1'b0;
   logic                  hit_limit = 1'b0;
   logic                  string_closed = 1'b0;

   always #(CLK_HALF) clock = ~clock;

   invisible_char_stripper_core #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Length of the banned byte or sequence that starts at b0, zero when b0 is kept.
   function automatic int banned_length(logic [7:0] b0, logic [7:0] b1,
                                        logic [7:0] b2, logic [7:0] b3);
      if (b0 < CH_CTRL_END) return 1;
      if (b0 > CH_TAB && b0 < CH_SPACE) return 1;
      if (b0 == CH_DEL) return 1;
      if (b0 == CH_LEAD_C2 && (b1 == CH_CONT_A0 || b1 == CH_CONT_AD)) return 2;
      if (b0 == CH_LEAD_E2 && b1 == CH_CONT_80 && b2 >= CH_CONT_80 && b2 <= CH_CONT_AF)
         return 3;
      if (b0 == CH_LEAD_E2 && b1 == CH_CONT_81 && b2 >= CH_CONT_A0 && b2 <= CH_CONT_AF)
         return 3;
      if (b0 == CH_LEAD_E1 && b1 == CH_CONT_A0 && b2 == CH_CONT_8E) return 3;
      if (b0 == CH_LEAD_EF && b1 == CH_CONT_BB && b2 == CH_CONT_BF) return 3;
      if (b0 == CH_LEAD_F3 && b1 == CH_CONT_A0 && b2 == CH_CONT_80 &&
          b3 >= CH_CONT_80 && b3 <= CH_CONT_BF) return 4;
      if (b0 == CH_LEAD_F3 && b1 == CH_CONT_A0 && b2 == CH_CONT_81 &&
          b3 >= CH_CONT_80 && b3 <= CH_CONT_AF) return 4;
      return 0;
   endfunction

   // Works out the results caused by one accepted byte and queues them.
   task automatic predict_kept_bytes(input logic [7:0] in_b, input logic last);
      logic [7:0]       win[4];
      logic [7:0]       b[4];
      strip_result_type res[4];
      int               cnt;
      int               n;
      int               k;
      logic             flush;
      n = 0;
      if (!string_closed) begin
         cnt = win_fill;
         for (int i = 0; i < 4; i++) win[i] = (i < cnt) ? win_bytes[i] : 8'h00;
         if (in_b != 8'h00) begin
            win[cnt] = in_b;
            cnt++;
         end
         flush = (in_b == 8'h00) || last;
         // A full window decides one byte; a string end decides all held bytes.
         while (cnt == 4 || (flush && cnt > 0)) begin
            for (int i = 0; i < 4; i++) b[i] = (i < cnt) ? win[i] : 8'h00;
            k = banned_length(b[0], b[1], b[2], b[3]);
            if (sent_count >= limit_reg || sent_count == CNT_MAX) hit_limit = 1'b1;
            if (k != 0) begin
               saw_banned = 1'b1;
            end else begin
               k = 1;
               if (!hit_limit) begin
                  if (n < 4) begin
                     res[n] = '{b[0], 1'b1, 1'b0, 1'b0, 1'b0};
                     n++;
                  end
                  sent_count++;
               end
            end
            if (k > cnt) k = cnt;
            for (int i = 0; i + k < cnt; i++) win[i] = win[i + k];
            cnt -= k;
         end
         if (flush) string_closed = 1'b1;
         for (int i = 0; i < 3; i++) win_bytes[i] = (i < cnt) ? win[i] : 8'h00;
         win_fill = cnt;
      end
      if (last) begin
         if (n == 0) begin
            res[0] = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
            n = 1;
         end
         res[n-1].end_of_run  = 1'b1;
         res[n-1].removed_any = saw_banned;
         res[n-1].truncated   = hit_limit;
         for (int i = 0; i < 3; i++) win_bytes[i] = 8'h00;
         win_fill      = 0;
         sent_count    = '0;
         saw_banned    = 1'b0;
         hit_limit     = 1'b0;
         string_closed = 1'b0;
      end
      for (int i = 0; i < n; i++) expected_results.push_back(res[i]);
   endtask

   // Monitor: both handshakes are sampled at the rising edge, before the block updates.
   always @(posedge clock) begin
      strip_result_type exp_res;
      logic [15:0]      exp_data;
      if (reset) begin
         req_taken    = 1'b0;
         quiet_cycles = 0;
      end else begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            predict_kept_bytes(req_tdata, req_tlast);
            bytes_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, got data %h user %b last %b",
                        $time, rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               exp_res  = expected_results.pop_front();
               exp_data = {6'd0, exp_res.truncated, exp_res.removed_any, exp_res.out_byte};
               if (rsp_tdata !== exp_data || rsp_tuser !== exp_res.byte_valid ||
                   rsp_tlast !== exp_res.end_of_run) begin
                  $display("%0t: mismatch: expected data %h user %b last %b,",
                           $time, exp_data, exp_res.byte_valid, exp_res.end_of_run,
                           " got data %h user %b last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
                  mismatch_count++;
               end
            end
         end
         // Watchdog: any transaction on either side counts as progress.
         if (req_taken || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles, giving up", $time, STALL_LIMIT);
               $display("Mismatches found");
               $finish;
            end
         end
      end
   end

   // Driver: offers the next pending byte at the falling edge, with gaps as the pace asks.
   always @(negedge clock) begin
      byte_item_type item;
      logic          gap;
      if (!reset && (!req_tvalid || req_taken)) begin
         case (pace)
            PACE_RX_STALLS: gap = ($urandom_range(0, 99) < 6);
            PACE_TX_GAPS:   gap = ($urandom_range(0, 99) < 55);
            default:        gap = 1'b0;
         endcase
         if (pending_bytes.size() > 0 && !gap) begin
            item = pending_bytes.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= item.data;
            req_tlast  <= item.last;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus two long hold-offs once enough bytes have gone in,
   // so that the output queue and the window fill up and the input is stalled.
   always @(negedge clock) begin
      static int hold_left = 0;
      static int holds_done = 0;
      logic      stall;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if ((holds_done == 0 && bytes_accepted >= 40) ||
                   (holds_done == 1 && bytes_accepted >= 260)) begin
         holds_done++;
         hold_left = HOLD_LEN - 1;
         rsp_tready <= 1'b0;
      end else begin
         case (pace)
            PACE_RX_STALLS: stall = ($urandom_range(0, 99) < 55);
            PACE_TX_GAPS:   stall = ($urandom_range(0, 99) < 6);
            default:        stall = 1'b0;
         endcase
         rsp_tready <= !stall;
      end
   end

   // Queues one string, with tlast on its final byte.
   task automatic queue_string(input logic [7:0] str[$]);
      byte_item_type item;
      foreach (str[i]) begin
         item.data = str[i];
         item.last = (i == str.size() - 1);
         pending_bytes.push_back(item);
      end
   endtask

   // Appends one banned UTF-8 sequence with random content in its allowed range, or a
   // broken lookalike that usually survives.
   task automatic append_sequence(ref logic [7:0] str[$]);
      case ($urandom_range(0, 7))
         0: begin
            str.push_back(CH_LEAD_C2);
            str.push_back($urandom_range(0, 1) ? CH_CONT_A0 : CH_CONT_AD);
         end
         1: begin
            str.push_back(CH_LEAD_E2);
            str.push_back(CH_CONT_80);
            str.push_back(8'($urandom_range(8'h80, 8'hAF)));
         end
         2: begin
            str.push_back(CH_LEAD_E2);
            str.push_back(CH_CONT_81);
            str.push_back(8'($urandom_range(8'hA0, 8'hAF)));
         end
         3: begin
            str.push_back(CH_LEAD_E1);
            str.push_back(CH_CONT_A0);
            str.push_back(CH_CONT_8E);
         end
         4: begin
            str.push_back(CH_LEAD_EF);
            str.push_back(CH_CONT_BB);
            str.push_back(CH_CONT_BF);
         end
         5: begin
            str.push_back(CH_LEAD_F3);
            str.push_back(CH_CONT_A0);
            str.push_back(CH_CONT_80);
            str.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
         6: begin
            str.push_back(CH_LEAD_F3);
            str.push_back(CH_CONT_A0);
            str.push_back(CH_CONT_81);
            str.push_back(8'($urandom_range(8'h80, 8'hAF)));
         end
         default: begin
            case ($urandom_range(0, 4))
               0:       str.push_back(CH_LEAD_C2);
               1:       str.push_back(CH_LEAD_E1);
               2:       str.push_back(CH_LEAD_E2);
               3:       str.push_back(CH_LEAD_EF);
               default: str.push_back(CH_LEAD_F3);
            endcase
            repeat ($urandom_range(1, 3)) str.push_back(8'($urandom_range(8'h80, 8'hBF)));
         end
      endcase
   endtask

   // Fills the pending queue with random strings until about target bytes are queued.
   // Strings are mostly short; a cut at the string length may leave a sequence unfinished.
   task automatic queue_random_strings(input int target);
      logic [7:0] str[$];
      int         added;
      int         len;
      int         pick;
      added = 0;
      while (added < target) begin
         str.delete();
         len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 24);
         while (str.size() < len) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      append_sequence(str);
            else if (pick < 60) str.push_back(8'($urandom_range(8'h00, 8'h20)));
            else if (pick < 63) str.push_back(CH_DEL);
            else if (pick < 97) str.push_back(8'($urandom_range(0, 255)));
            else                str.push_back(8'h00);
         end
         while (str.size() > len) void'(str.pop_back());
         queue_string(str);
         added += str.size();
      end
   endtask

   // Waits until every byte has been taken and every result has come, then lets the
   // block settle.
   task automatic wait_until_idle();
      while (pending_bytes.size() != 0 || req_tvalid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_limit(input logic [15:0] value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      limit_reg = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      logic [7:0] str[$];
      for (int i = 0; i < 3; i++) win_bytes[i] = 8'h00;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed strings: control-byte boundaries, the extremes of the byte, a few
      // banned sequences, a terminator before the end, and a string that leaves nothing.
      pace = PACE_RX_STALLS;
      write_out_limit(16'd255);
      str = '{8'h07, 8'h08, 8'h09, 8'h1F, 8'h20, 8'h7F, 8'hFF, 8'hC2, 8'hAD, 8'h41};
      queue_string(str);
      str = '{8'hE2, 8'h80, 8'hAF, 8'hF3, 8'hA0, 8'h81, 8'h80, 8'hEF, 8'hBB, 8'hBF};
      queue_string(str);
      str = '{8'h41, 8'h00, 8'h42};
      queue_string(str);
      str = '{8'h0A};
      queue_string(str);
      queue_random_strings(80);

      // Small limits make truncation common; zero stops every string at once.
      wait_until_idle();
      pace = PACE_TX_GAPS;
      write_out_limit(16'd3);
      queue_random_strings(80);
      wait_until_idle();
      write_out_limit(16'd0);
      queue_random_strings(30);

      wait_until_idle();
      pace = PACE_FULL_RATE;
      write_out_limit(16'hFFFF);
      queue_random_strings(70);
      wait_until_idle();
      write_out_limit(16'd1);
      queue_random_strings(30);

      wait_until_idle();
      if (expected_results.size() != 0)
         $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/core/ics_pkg.sv
rtl/core/ics_match.sv
rtl/core/invisible_char_stripper_core.sv
verif/testbench.sv
